// File: sv/wss_pkg.sv
// Shared types, constants and helper functions of the windowed sample statistics block.
package wss_pkg;

	localparam int MAX_BINS = 64;
	localparam int BIN_AW = $clog2(MAX_BINS);
	localparam int BIN_NW = $clog2(MAX_BINS + 1);

	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic REG_ENABLED = 1'b0;
	localparam logic REG_BIN_COUNT = 1'b1;

	localparam logic [1:0] KIND_MUL = 2'd0;
	localparam logic [1:0] KIND_DIV = 2'd1;
	localparam logic [1:0] KIND_SQRT = 2'd2;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_AVG = 4'd1;
	localparam logic [3:0] OP_MULA = 4'd2;
	localparam logic [3:0] OP_MULB = 4'd3;
	localparam logic [3:0] OP_DIV1 = 4'd4;
	localparam logic [3:0] OP_DIV2 = 4'd5;
	localparam logic [3:0] OP_SQRT = 4'd6;
	localparam logic [3:0] OP_SRATE = 4'd7;
	localparam logic [3:0] OP_VRATE = 4'd8;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [39:0] cnt;
		logic signed [63:0] sum;
		logic [63:0] sq;
		logic [47:0] dur;
		logic signed [31:0] mn;
		logic signed [31:0] mx;
	} stats_t;

	localparam stats_t STATS_EMPTY = '{cnt: 40'd0, sum: 64'sd0, sq: 64'd0, dur: 48'd0,
		mn: S32_MAX, mx: S32_MIN};

	typedef struct packed {
		logic sample;
		logic clear;
		logic tick;
		logic sweep_rd;
		logic load;
		logic win;
		logic start;
		logic [3:0] op;
	} wss_cmd_t;

	typedef struct packed {
		logic enabled;
		logic started;
		logic sweep_last;
		logic cnt_nz;
		logic dur_nz;
		logic var_pos;
		logic ar_done;
	} wss_stat_t;

	function automatic logic signed [63:0] add_sat_s64(logic signed [63:0] a,
		logic signed [63:0] b);
		logic signed [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63]) begin
			r = a[63] ? S64_MIN : S64_MAX;
		end
		return r;
	endfunction

	function automatic logic [63:0] add_sat_u64(logic [63:0] a, logic [63:0] b);
		logic [64:0] r;
		r = {1'b0, a} + {1'b0, b};
		return r[64] ? '1 : r[63:0];
	endfunction

	function automatic stats_t merge_stats(stats_t d, stats_t s);
		logic [40:0] c;
		logic [48:0] u;
		stats_t o;
		c = {1'b0, d.cnt} + {1'b0, s.cnt};
		u = {1'b0, d.dur} + {1'b0, s.dur};
		o.cnt = c[40] ? '1 : c[39:0];
		o.dur = u[48] ? '1 : u[47:0];
		o.sum = add_sat_s64(d.sum, s.sum);
		o.sq = add_sat_u64(d.sq, s.sq);
		o.mn = (s.mn < d.mn) ? s.mn : d.mn;
		o.mx = (s.mx > d.mx) ? s.mx : d.mx;
		return o;
	endfunction

endpackage

// File: sv/windowed_sample_statistics.sv
// Top level of the windowed sample statistics block.
//
//  Channel   Direction  Handshake            Contents
//  input     in         in_valid / in_stall  mode, sample_value, time_now
//  output    out        out_valid/out_stall  window, last_of_run and the statistics fields
//  config    in         cfg_we               cfg_index, cfg_data (no read-back)
//
// A sample, clear or ignored item is accepted whenever the block is idle. A tick that starts
// a run sweeps the bins in use and then works out each of the two results on one shared
// bit-serial arithmetic unit, with its 128-step divisions and 64-step products and root.
// Reset clears all statistics at once; the bins carry valid flags, so no clearing pass.
// While out_valid is high and out_stall holds it, the result waits and no input is taken.
module windowed_sample_statistics import wss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] mode,
	input logic signed [31:0] sample_value,
	input logic [47:0] time_now,
	output logic out_valid,
	input logic out_stall,
	output logic window,
	output logic last_of_run,
	output logic [39:0] sample_count,
	output logic signed [63:0] value_sum,
	output logic signed [31:0] value_min,
	output logic signed [31:0] value_max,
	output logic signed [39:0] average,
	output logic [39:0] rms,
	output logic [63:0] sample_rate,
	output logic signed [63:0] value_rate,
	output logic [47:0] duration,
	output logic signed [31:0] last_sample,
	input logic cfg_we,
	input logic cfg_index,
	input logic [6:0] cfg_data
);

	wss_cmd_t cmd;
	wss_stat_t st;

	// The controller owns the handshakes and the order of the work.
	wss_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.mode(mode),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.st(st),
		.cmd(cmd)
	);

	// The datapath holds every accumulator, the bin ring and the result registers.
	wss_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_value(sample_value),
		.time_now(time_now),
		.window(window),
		.sample_count(sample_count),
		.value_sum(value_sum),
		.value_min(value_min),
		.value_max(value_max),
		.average(average),
		.rms(rms),
		.sample_rate(sample_rate),
		.value_rate(value_rate),
		.duration(duration),
		.last_sample(last_sample)
	);

	// The recent-window result is always the second and last of a run.
	assign last_of_run = window;

endmodule

// File: sv/wss_arith.sv
// Shared bit-serial multiply, divide and square root unit.
module wss_arith import wss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] kind,
	input logic [127:0] opa,
	input logic [63:0] opb,
	output logic [127:0] res,
	output logic done
);

	logic busy_q;
	logic done_q;
	logic [6:0] cnt_q;
	logic [1:0] kind_q;
	logic [127:0] sh_q;
	logic [127:0] acc_q;
	logic [63:0] b_q;
	logic [66:0] rem_q;
	logic [63:0] root_q;

	logic [127:0] sh_d;
	logic [127:0] acc_d;
	logic [66:0] rem_d;
	logic [63:0] root_d;
	logic [48:0] drt;
	logic [48:0] dvs;
	logic [66:0] srt;
	logic [66:0] trial;
	logic ge;

	always_comb begin
		sh_d = sh_q;
		acc_d = acc_q;
		rem_d = rem_q;
		root_d = root_q;
		drt = {rem_q[47:0], sh_q[127]};
		dvs = {1'b0, b_q[47:0]};
		srt = {rem_q[64:0], sh_q[127:126]};
		trial = {1'b0, root_q, 2'b01};
		ge = 1'b0;
		case (kind_q)
			KIND_MUL: begin
				acc_d = {acc_q[126:0], 1'b0} + (sh_q[63] ? {64'd0, b_q} : 128'd0);
				sh_d = {sh_q[126:0], 1'b0};
			end
			KIND_DIV: begin
				ge = drt >= dvs;
				rem_d = {18'd0, ge ? drt - dvs : drt};
				sh_d = {sh_q[126:0], ge};
			end
			KIND_SQRT: begin
				ge = srt >= trial;
				rem_d = ge ? srt - trial : srt;
				root_d = {root_q[62:0], ge};
				sh_d = {sh_q[125:0], 2'b00};
			end
			default: begin
				sh_d = sh_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && cnt_q == 7'd0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= (kind == KIND_DIV) ? 7'd127 : 7'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= kind;
			sh_q <= opa;
			b_q <= opb;
			acc_q <= '0;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			sh_q <= sh_d;
			acc_q <= acc_d;
			rem_q <= rem_d;
			root_q <= root_d;
		end
	end

	always_comb begin
		case (kind_q)
			KIND_MUL: res = acc_q;
			KIND_DIV: res = sh_q;
			KIND_SQRT: res = {64'd0, root_q};
			default: res = '0;
		endcase
	end

	assign done = done_q;

endmodule

// File: sv/wss_ctrl.sv
// Controller state machine that sequences items, the bin sweep and the result math.
module wss_ctrl import wss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] mode,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input wss_stat_t st,
	output wss_cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SWEEP = 4'd1;
	localparam logic [3:0] S_SWEEP_END = 4'd2;
	localparam logic [3:0] S_LOAD = 4'd3;
	localparam logic [3:0] S_CHK = 4'd4;
	localparam logic [3:0] S_AVG = 4'd5;
	localparam logic [3:0] S_MULA = 4'd6;
	localparam logic [3:0] S_MULB = 4'd7;
	localparam logic [3:0] S_CMP = 4'd8;
	localparam logic [3:0] S_DIV1 = 4'd9;
	localparam logic [3:0] S_DIV2 = 4'd10;
	localparam logic [3:0] S_SQRT = 4'd11;
	localparam logic [3:0] S_SRATE = 4'd12;
	localparam logic [3:0] S_VRATE = 4'd13;
	localparam logic [3:0] S_OUT = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic win_q;
	logic win_d;
	logic launch_q;
	logic acc;
	logic [3:0] op;
	logic [3:0] rate_next;

	assign acc = in_valid && state_q == S_IDLE;
	assign rate_next = st.dur_nz ? S_SRATE : S_OUT;

	always_comb begin
		case (state_q)
			S_AVG: op = OP_AVG;
			S_MULA: op = OP_MULA;
			S_MULB: op = OP_MULB;
			S_DIV1: op = OP_DIV1;
			S_DIV2: op = OP_DIV2;
			S_SQRT: op = OP_SQRT;
			S_SRATE: op = OP_SRATE;
			S_VRATE: op = OP_VRATE;
			default: op = OP_NONE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		win_d = win_q;
		case (state_q)
			S_IDLE: begin
				if (acc && mode == MODE_TICK && st.enabled && st.started) begin
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: if (st.sweep_last) state_d = S_SWEEP_END;
			S_SWEEP_END: begin
				win_d = 1'b0;
				state_d = S_LOAD;
			end
			S_LOAD: state_d = S_CHK;
			S_CHK: state_d = st.cnt_nz ? S_AVG : rate_next;
			S_AVG: if (st.ar_done) state_d = S_MULA;
			S_MULA: if (st.ar_done) state_d = S_MULB;
			S_MULB: if (st.ar_done) state_d = S_CMP;
			S_CMP: state_d = st.var_pos ? S_DIV1 : rate_next;
			S_DIV1: if (st.ar_done) state_d = S_DIV2;
			S_DIV2: if (st.ar_done) state_d = S_SQRT;
			S_SQRT: if (st.ar_done) state_d = rate_next;
			S_SRATE: if (st.ar_done) state_d = S_VRATE;
			S_VRATE: if (st.ar_done) state_d = S_OUT;
			S_OUT: begin
				if (!out_stall) begin
					if (win_q) begin
						state_d = S_IDLE;
					end else begin
						win_d = 1'b1;
						state_d = S_LOAD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			win_q <= 1'b0;
			launch_q <= 1'b0;
		end else begin
			state_q <= state_d;
			win_q <= win_d;
			launch_q <= (state_d != state_q) && (state_d inside {S_AVG, S_MULA, S_MULB,
				S_DIV1, S_DIV2, S_SQRT, S_SRATE, S_VRATE});
		end
	end

	assign in_stall = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_comb begin
		cmd.sample = acc && mode == MODE_SAMPLE && st.enabled;
		cmd.clear = acc && mode == MODE_CLEAR;
		cmd.tick = acc && mode == MODE_TICK && st.enabled && st.started;
		cmd.sweep_rd = state_q == S_SWEEP;
		cmd.load = state_q == S_LOAD;
		cmd.win = win_q;
		cmd.start = launch_q;
		cmd.op = op;
	end

endmodule

// File: sv/wss_dp.sv
// Datapath: accumulators, bin memory, sweep merge and result registers.
module wss_dp import wss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input wss_cmd_t cmd,
	output wss_stat_t st,
	input logic cfg_we,
	input logic cfg_index,
	input logic [6:0] cfg_data,
	input logic signed [31:0] sample_value,
	input logic [47:0] time_now,
	output logic window,
	output logic [39:0] sample_count,
	output logic signed [63:0] value_sum,
	output logic signed [31:0] value_min,
	output logic signed [31:0] value_max,
	output logic signed [39:0] average,
	output logic [39:0] rms,
	output logic [63:0] sample_rate,
	output logic signed [63:0] value_rate,
	output logic [47:0] duration,
	output logic signed [31:0] last_sample
);

	logic enabled_q;
	logic [6:0] bin_count_q;
	logic started_q;
	logic [47:0] last_tick_q;
	stats_t work_q;
	stats_t total_q;
	stats_t recent_q;
	logic [BIN_AW-1:0] ptr_q;
	logic [MAX_BINS-1:0] valid_q;
	logic [BIN_AW-1:0] idx_q;
	logic rd_s1;
	logic vld_s1;
	stats_t mem_s1;
	logic signed [31:0] prev_q;
	stats_t bin_mem [MAX_BINS];

	stats_t e_q;
	logic e_win_q;
	logic [127:0] t_q;
	logic [127:0] ta_q;
	logic var_pos_q;
	logic [39:0] avg_q;
	logic [39:0] rms_q;
	logic [63:0] srate_q;
	logic [63:0] vrate_q;

	logic clear_all;
	logic [BIN_NW-1:0] nbins;
	logic [BIN_AW-1:0] p;
	logic [BIN_NW-1:0] p_inc;
	logic [BIN_AW-1:0] ptr_next;
	stats_t latest;
	logic [31:0] smag;
	logic [63:0] ssq;
	logic neg;
	logic [63:0] mag;
	logic [1:0] kind;
	logic [127:0] opa;
	logic [63:0] opb;
	logic [127:0] ares;
	logic adone;
	logic [39:0] lim40;
	logic [63:0] lim64;
	logic [39:0] m40;
	logic [63:0] m64;

	assign clear_all = cmd.clear
		|| (cfg_we && cfg_index == REG_BIN_COUNT)
		|| (cfg_we && cfg_index == REG_ENABLED && !enabled_q && cfg_data[0]);

	always_comb begin
		if (bin_count_q == 7'd0) begin
			nbins = BIN_NW'(1);
		end else if (BIN_NW'(bin_count_q) > BIN_NW'(MAX_BINS)
			|| bin_count_q > 7'(MAX_BINS)) begin
			nbins = BIN_NW'(MAX_BINS);
		end else begin
			nbins = BIN_NW'(bin_count_q);
		end
		p = ({1'b0, ptr_q} >= nbins) ? '0 : ptr_q;
		p_inc = {1'b0, p} + BIN_NW'(1);
		ptr_next = (p_inc >= nbins) ? '0 : p_inc[BIN_AW-1:0];
		latest = work_q;
		latest.dur = (time_now >= last_tick_q) ? time_now - last_tick_q : 48'd0;
		smag = sample_value[31] ? 32'(-sample_value) : 32'(sample_value);
		ssq = 64'(smag) * 64'(smag);
	end

	// Accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			bin_count_q <= 7'd1;
			started_q <= 1'b0;
			last_tick_q <= '0;
			work_q <= STATS_EMPTY;
			total_q <= STATS_EMPTY;
			recent_q <= STATS_EMPTY;
			ptr_q <= '0;
			valid_q <= '0;
			idx_q <= '0;
			rd_s1 <= 1'b0;
			prev_q <= '0;
		end else begin
			rd_s1 <= cmd.sweep_rd;
			if (cfg_we && cfg_index == REG_ENABLED) enabled_q <= cfg_data[0];
			if (cfg_we && cfg_index == REG_BIN_COUNT) bin_count_q <= cfg_data;
			if (clear_all) begin
				started_q <= 1'b0;
				last_tick_q <= '0;
				work_q <= STATS_EMPTY;
				total_q <= STATS_EMPTY;
				ptr_q <= '0;
				valid_q <= '0;
			end else if (cmd.sample) begin
				if (!started_q) begin
					started_q <= 1'b1;
					last_tick_q <= time_now;
				end
				work_q.cnt <= (work_q.cnt == '1) ? work_q.cnt : work_q.cnt + 40'd1;
				work_q.sum <= add_sat_s64(work_q.sum, 64'(sample_value));
				work_q.sq <= add_sat_u64(work_q.sq, ssq);
				if (sample_value < work_q.mn) work_q.mn <= sample_value;
				if (sample_value > work_q.mx) work_q.mx <= sample_value;
				prev_q <= sample_value;
			end else if (cmd.tick) begin
				last_tick_q <= time_now;
				work_q <= STATS_EMPTY;
				total_q <= merge_stats(total_q, latest);
				valid_q[p] <= 1'b1;
				ptr_q <= ptr_next;
				recent_q <= STATS_EMPTY;
				idx_q <= '0;
			end
			if (cmd.sweep_rd) idx_q <= idx_q + BIN_AW'(1);
			if (rd_s1) recent_q <= merge_stats(recent_q, vld_s1 ? mem_s1 : STATS_EMPTY);
		end
	end

	// Bin memory, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.tick) bin_mem[p] <= latest;
		if (cmd.sweep_rd) begin
			mem_s1 <= bin_mem[idx_q];
			vld_s1 <= valid_q[idx_q];
		end
	end

	assign neg = e_q.sum[63];
	assign mag = neg ? 64'(-e_q.sum) : 64'(e_q.sum);

	always_comb begin
		kind = KIND_DIV;
		opa = '0;
		opb = {24'd0, e_q.cnt};
		case (cmd.op)
			OP_AVG: opa = {56'd0, mag, 8'd0} + {89'd0, e_q.cnt[39:1]};
			OP_MULA: begin
				kind = KIND_MUL;
				opa = {88'd0, e_q.cnt};
				opb = e_q.sq;
			end
			OP_MULB: begin
				kind = KIND_MUL;
				opa = {64'd0, mag};
				opb = mag;
			end
			OP_DIV1: opa = {t_q[111:0], 16'd0};
			OP_DIV2: opa = t_q;
			OP_SQRT: begin
				kind = KIND_SQRT;
				opa = t_q;
			end
			OP_SRATE: begin
				opa = {72'd0, e_q.cnt, 16'd0};
				opb = {16'd0, e_q.dur};
			end
			OP_VRATE: begin
				opa = {48'd0, mag, 16'd0};
				opb = {16'd0, e_q.dur};
			end
			default: opa = '0;
		endcase
	end

	wss_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.start),
		.kind(kind),
		.opa(opa),
		.opb(opb),
		.res(ares),
		.done(adone)
	);

	always_comb begin
		lim40 = neg ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
		lim64 = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		m40 = (ares > {88'd0, lim40}) ? lim40 : ares[39:0];
		m64 = (ares > {64'd0, lim64}) ? lim64 : ares[63:0];
	end

	// Result math registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q <= cmd.win ? recent_q : total_q;
			e_win_q <= cmd.win;
			var_pos_q <= 1'b0;
			avg_q <= '0;
			rms_q <= '0;
			srate_q <= '0;
			vrate_q <= '0;
		end else if (adone) begin
			case (cmd.op)
				OP_AVG: avg_q <= neg ? 40'(-m40) : m40;
				OP_MULA: ta_q <= ares;
				OP_MULB: begin
					var_pos_q <= ta_q > ares;
					t_q <= ta_q - ares;
				end
				OP_DIV1, OP_DIV2: t_q <= ares;
				OP_SQRT: rms_q <= (ares[127:40] != '0) ? '1 : ares[39:0];
				OP_SRATE: srate_q <= ares[63:0];
				OP_VRATE: vrate_q <= neg ? 64'(-m64) : m64;
				default: t_q <= t_q;
			endcase
		end
	end

	always_comb begin
		st.enabled = enabled_q;
		st.started = started_q;
		st.sweep_last = {1'b0, idx_q} == nbins - BIN_NW'(1);
		st.cnt_nz = e_q.cnt != '0;
		st.dur_nz = e_q.dur != '0;
		st.var_pos = var_pos_q;
		st.ar_done = adone;
	end

	assign window = e_win_q;
	assign sample_count = e_q.cnt;
	assign value_sum = e_q.sum;
	assign value_min = e_q.mn;
	assign value_max = e_q.mx;
	assign average = avg_q;
	assign rms = rms_q;
	assign sample_rate = srate_q;
	assign value_rate = vrate_q;
	assign duration = e_q.dur;
	assign last_sample = prev_q;

endmodule
